@@ rtl/core/lmsu_pkg.sv @@
// package: shared constants and codes for the linear model score/update block
`timescale 1ns / 1ps
package lmsu_pkg;

  localparam int DEF_MAX_DIMS = 64;
  localparam int DATA_W       = 32;
  localparam int GRAD_W       = 48;
  localparam int DIV_W        = 16;
  localparam int DIMS_W       = 7;
  localparam int ADDR_W       = 3;

  typedef enum logic [1:0] {
    OP_SCORE = 2'd0,
    OP_ACCUM = 2'd1,
    OP_APPLY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic KIND_SCORE  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic REG_RATE = 1'b0;
  localparam logic REG_DIMS = 1'b1;

  localparam logic [DATA_W-1:0] WEIGHT_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RATE_RESET = 32'h0001_0000;

endpackage

@@ rtl/core/lmsu_div.sv @@
// module: signed-by-unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lmsu_div
  import lmsu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [GRAD_W-1:0] dividend,
  input  logic        [DIV_W-1:0]  divisor,
  output logic                     done,
  output logic signed [GRAD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(GRAD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  rem;
  logic [GRAD_W-1:0] q_sh;
  logic              neg;
  logic [DIV_W:0]    rem_s;
  logic              ge;
  logic [DIV_W:0]    rem_d;

  assign rem_s = {rem, q_sh[GRAD_W-1]};
  assign ge    = rem_s >= {1'b0, divisor};
  assign rem_d = rem_s - {1'b0, divisor};
  assign quotient = neg ? -$signed(q_sh) : $signed(q_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(GRAD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[GRAD_W-1];
      q_sh <= dividend[GRAD_W-1] ? 48'(-dividend) : dividend;
      rem  <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_d[DIV_W-1:0] : rem_s[DIV_W-1:0];
      q_sh <= {q_sh[GRAD_W-2:0], ge};
    end
  end

endmodule

@@ rtl/core/linear_model_score_and_update.sv @@
// top level: linear model scoring and batch gradient update with a shared multiplier
// score element: multiply, then accumulate; the last element also waits in a final state for the output register
// accumulate element: multiply, magnitude, high and low rate products, sum, add (second pass adds the bias gradient)
// apply: read, 48-step divider, write, for each of dims+1 weights, then one result beat
// clear: handled in idle; one item in flight, input stalled until the sequencer is back in idle
// rst (synchronous): weights read 1.0, gradients 0, rate 1.0, dims 64, output empty
`timescale 1ns / 1ps
module linear_model_score_and_update
  import lmsu_pkg::*;
#(
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                     clk,
  input  logic                     rst,
  // input beats
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic signed [DATA_W-1:0] feature,
  input  logic signed [DATA_W-1:0] mult,
  input  logic [DIV_W-1:0]         batch_size,
  // result beats
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     result_kind,
  output logic signed [DATA_W-1:0] score_value,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int DEPTH = MAX_DIMS + 1;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_SC_MUL  = 15'b000000000000010,
    S_SC_ACC  = 15'b000000000000100,
    S_SC_FIN  = 15'b000000000001000,
    S_AC_MUL  = 15'b000000000010000,
    S_AC_MAG  = 15'b000000000100000,
    S_AC_HI   = 15'b000000001000000,
    S_AC_LO   = 15'b000000010000000,
    S_AC_SUM  = 15'b000000100000000,
    S_AC_ADD  = 15'b000001000000000,
    S_AP_RD   = 15'b000010000000000,
    S_AP_DIV  = 15'b000100000000000,
    S_AP_WAIT = 15'b001000000000000,
    S_AP_WR   = 15'b010000000000000,
    S_AP_FIN  = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration
  logic [DATA_W-1:0] step_rate;
  logic [DIMS_W-1:0] dims_in_use;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_DIMS) ? {25'd0, dims_in_use} : step_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate   <= RATE_RESET;
      dims_in_use <= DIMS_W'(64);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DIMS) dims_in_use <= pwdata[DIMS_W-1:0];
      else                      step_rate <= pwdata;
    end
  end

  // effective dimension count: zero reads as one, clipped at the store size
  logic [IDX_W-1:0] d;
  always_comb begin
    if (dims_in_use == '0)                d = IDX_W'(1);
    else if (int'(dims_in_use) > MAX_DIMS) d = IDX_W'(MAX_DIMS);
    else                                   d = IDX_W'(dims_in_use);
  end

  // stream state
  logic [IDX_W-1:0]   element_index;
  logic signed [63:0] score_accumulator;
  logic [IDX_W-1:0]   idx_c;
  logic [IDX_W-1:0]   cur_idx;
  logic               last;
  logic               bias_phase;

  assign idx_c = (element_index > d - 1'b1) ? d - 1'b1 : element_index;

  // latched beat
  logic signed [DATA_W-1:0] feature_r;
  logic signed [DATA_W-1:0] mult_r;
  logic [DIV_W-1:0]         div_n;

  // weight and gradient stores, valid bit clear means the reset value
  logic [DATA_W-1:0] wmem [DEPTH];
  logic [GRAD_W-1:0] gmem [DEPTH];
  logic [DEPTH-1:0]  wvalid;
  logic [DEPTH-1:0]  gvalid;
  logic [DATA_W-1:0] w_rd;
  logic [GRAD_W-1:0] g_rd;
  logic              w_rd_v;
  logic              g_rd_v;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              w_we;
  logic              g_we;
  logic [DATA_W-1:0] w_wdata;
  logic [GRAD_W-1:0] g_wdata;
  logic signed [DATA_W-1:0] w_val;
  logic signed [GRAD_W-1:0] g_val;

  assign w_val = w_rd_v ? w_rd : WEIGHT_ONE;
  assign g_val = g_rd_v ? g_rd : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      w_rd <= wmem[rd_addr];
      g_rd <= gmem[rd_addr];
    end
    if (w_we) wmem[cur_idx] <= w_wdata;
    if (g_we) gmem[cur_idx] <= g_wdata;
  end

  // read address per step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_c;
    case (state)
      S_IDLE:   rd_en = 1'b1;
      S_SC_MUL: begin rd_en = 1'b1; rd_addr = d; end
      S_AC_ADD: begin rd_en = 1'b1; rd_addr = d; end
      S_AP_RD:  begin rd_en = 1'b1; rd_addr = cur_idx; end
      default:  rd_en = 1'b0;
    endcase
  end

  // shared multiplier, result registered in prod
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  mul_p;
  logic signed [63:0]  prod;
  logic [47:0]         mag;
  logic                neg;
  logic [63:0]         hi_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SC_MUL: begin
        mul_a = {feature_r[DATA_W-1], feature_r};
        mul_b = {w_val[DATA_W-1], w_val};
      end
      S_AC_MUL: begin
        mul_a = {feature_r[DATA_W-1], feature_r};
        mul_b = {mult_r[DATA_W-1], mult_r};
      end
      S_AC_HI: begin
        mul_a = {1'b0, mag[47:16]};
        mul_b = {1'b0, step_rate};
      end
      S_AC_LO: begin
        mul_a = {17'd0, mag[15:0]};
        mul_b = {1'b0, step_rate};
      end
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // gradient term: magnitude source, rate scaling with truncation and 48-bit limit
  logic signed [47:0] x_src;
  logic [63:0]        p_sum;
  logic [63:0]        p_lim;
  logic [63:0]        p_sat;
  logic signed [47:0] term;
  logic signed [48:0] g_sum;

  assign x_src = bias_phase ? 48'(mult_r) : prod[63:16];
  assign p_sum = hi_r + {16'd0, prod[63:16]};
  assign p_lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
  assign p_sat = (p_sum > p_lim) ? p_lim : p_sum;

  logic signed [47:0] term_r;
  assign term  = neg ? -$signed(p_sat[47:0]) : $signed(p_sat[47:0]);
  assign g_sum = 49'(g_val) + 49'(term_r);

  always_comb begin
    if (g_sum > 49'sh0_7FFF_FFFF_FFFF)       g_wdata = 48'h7FFF_FFFF_FFFF;
    else if (g_sum < -49'sh0_8000_0000_0000) g_wdata = 48'h8000_0000_0000;
    else                                     g_wdata = g_sum[47:0];
  end

  // score: saturating accumulate and final sum
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_next;
  logic signed [63:0] acc_sh;
  logic signed [31:0] acc32;
  logic signed [32:0] s33;
  logic signed [31:0] score_res;
  logic signed [DATA_W-1:0] bias_r;

  assign acc_sum = 65'(score_accumulator) + 65'(prod);
  always_comb begin
    if (acc_sum > 65'sh0_7FFF_FFFF_FFFF_FFFF)       acc_next = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (acc_sum < -65'sh0_8000_0000_0000_0000) acc_next = 64'sh8000_0000_0000_0000;
    else                                            acc_next = acc_sum[63:0];
  end

  assign acc_sh = score_accumulator >>> 16;
  always_comb begin
    if (acc_sh > 64'sh7FFF_FFFF)       acc32 = 32'sh7FFF_FFFF;
    else if (acc_sh < -64'sh8000_0000) acc32 = 32'sh8000_0000;
    else                               acc32 = acc_sh[31:0];
  end
  assign s33 = 33'(acc32) + 33'(bias_r);
  always_comb begin
    if (s33 > 33'sh0_7FFF_FFFF)       score_res = 32'sh7FFF_FFFF;
    else if (s33 < -33'sh0_8000_0000) score_res = 32'sh8000_0000;
    else                              score_res = s33[31:0];
  end

  // apply: weight minus quotient, saturated
  logic                     div_start;
  logic                     div_done;
  logic signed [GRAD_W-1:0] div_q;
  logic signed [DATA_W-1:0] w_hold;
  logic signed [48:0]       w_diff;

  // the divider takes the gradient straight from the read register
  assign div_start = (state == S_AP_DIV);
  assign w_diff    = 49'(w_hold) - 49'(div_q);
  always_comb begin
    if (w_diff > 49'sh7FFF_FFFF)       w_wdata = 32'h7FFF_FFFF;
    else if (w_diff < -49'sh8000_0000) w_wdata = 32'h8000_0000;
    else                               w_wdata = w_diff[31:0];
  end

  lmsu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (g_val),
    .divisor  (div_n),
    .done     (div_done),
    .quotient (div_q)
  );

  assign w_we = (state == S_AP_WR);
  assign g_we = (state == S_AC_ADD);

  // output register frees up when its beat is taken
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      element_index     <= '0;
      score_accumulator <= '0;
      bias_phase        <= 1'b0;
      out_valid         <= 1'b0;
      wvalid            <= '0;
      gvalid            <= '0;
      w_rd_v            <= 1'b0;
      g_rd_v            <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (rd_en) begin
        w_rd_v <= wvalid[rd_addr];
        g_rd_v <= gvalid[rd_addr];
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_idx <= idx_c;
            last    <= (idx_c == d - 1'b1);
            unique case (op_t'(operation))
              OP_SCORE: state <= S_SC_MUL;
              OP_ACCUM: state <= S_AC_MUL;
              OP_APPLY: begin
                element_index     <= '0;
                score_accumulator <= '0;
                cur_idx           <= '0;
                state             <= S_AP_RD;
              end
              OP_CLEAR: begin
                element_index     <= '0;
                score_accumulator <= '0;
                gvalid            <= '0;
              end
            endcase
          end
        end
        S_SC_MUL: state <= S_SC_ACC;
        S_SC_ACC: begin
          score_accumulator <= acc_next;
          bias_r            <= w_val;
          if (last) state <= S_SC_FIN;
          else begin
            element_index <= cur_idx + 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SC_FIN: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            result_kind       <= KIND_SCORE;
            score_value       <= score_res;
            element_index     <= '0;
            score_accumulator <= '0;
            state             <= S_IDLE;
          end
        end
        S_AC_MUL: state <= S_AC_MAG;
        S_AC_MAG: begin
          neg   <= x_src[47];
          mag   <= x_src[47] ? 48'(-x_src) : x_src;
          state <= S_AC_HI;
        end
        S_AC_HI: state <= S_AC_LO;
        S_AC_LO: begin
          hi_r  <= prod;
          state <= S_AC_SUM;
        end
        S_AC_SUM: begin
          term_r <= term;
          state  <= S_AC_ADD;
        end
        S_AC_ADD: begin
          gvalid[cur_idx] <= 1'b1;
          if (last && !bias_phase) begin
            // second pass adds rate*mult into the bias gradient
            bias_phase <= 1'b1;
            cur_idx    <= d;
            state      <= S_AC_MAG;
          end else begin
            bias_phase <= 1'b0;
            if (bias_phase) begin
              element_index     <= '0;
              score_accumulator <= '0;
            end else begin
              element_index <= cur_idx + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_AP_RD: state <= S_AP_DIV;
        S_AP_DIV: begin
          w_hold <= w_val;
          state  <= S_AP_WAIT;
        end
        S_AP_WAIT: begin
          if (div_done) state <= S_AP_WR;
        end
        S_AP_WR: begin
          wvalid[cur_idx] <= 1'b1;
          if (cur_idx == d) state <= S_AP_FIN;
          else begin
            cur_idx <= cur_idx + 1'b1;
            state   <= S_AP_RD;
          end
        end
        S_AP_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= KIND_UPDATE;
            score_value <= '0;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

  // payload registers of the beat and the shared multiplier
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      feature_r <= feature;
      mult_r    <= mult;
      div_n     <= (batch_size == '0) ? DIV_W'(1) : batch_size;
    end
    prod <= mul_p[63:0];
  end

endmodule

@@ verif/tb_linear_model_score_and_update.sv @@
// testbench: linear model score/update block, predictor-checked directed and random traffic
`timescale 1ns / 1ps
module tb_linear_model_score_and_update;
  import lmsu_pkg::*;

  localparam int  DIMS_CAP    = DEF_MAX_DIMS;
  localparam int  IDLE_LIMIT  = 20000;   // covers an apply at 64 dims, plus long hold-off
  localparam int  SETTLE      = 20;      // lets the tail of a last accumulate element finish
  localparam int  PHASE_ITEMS = 200;
  localparam int  PHASES      = 8;
  localparam longint G_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint G_MIN    = -G_MAX - 1;

  typedef struct packed {
    logic        kind;
    logic [31:0] score;
  } result_t;

  // one directed row: typed marks an expectation read straight off the behavior
  typedef struct {
    op_t         op;
    logic [31:0] feat;
    logic [31:0] mul;
    logic [15:0] batch;
    bit          typed;
    result_t     want;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               operation;
  logic signed [DATA_W-1:0] feature;
  logic signed [DATA_W-1:0] mult;
  logic [DIV_W-1:0]         batch_size;
  logic                     out_valid;
  logic                     out_stall;
  logic                     result_kind;
  logic signed [DATA_W-1:0] score_value;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  // mirror of the block state
  int          weight_mirror [0:DIMS_CAP];
  longint      grad_mirror   [0:DIMS_CAP];
  int          elem_mirror;
  longint      acc_mirror;
  logic [31:0] rate_mirror;
  logic [6:0]  dims_mirror;

  result_t pending_results[$];
  int      errors;
  int      items_sent;
  int      scores_seen;
  int      updates_seen;
  int      burst_left;
  int      idle_cycles;
  int      cyc;
  int      hold_left;
  bit      hold_req;

  always #1 clk = ~clk;

  linear_model_score_and_update i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .feature     (feature),
    .mult        (mult),
    .batch_size  (batch_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .score_value (score_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------- arithmetic helpers
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp48(input longint x);
    if (x > G_MAX) return G_MAX;
    if (x < G_MIN) return G_MIN;
    return x;
  endfunction

  // 64-bit saturating add for the score accumulator
  function automatic longint acc_add(input longint a, input longint b);
    logic signed [64:0] wide;
    wide = {a[63], a} + {b[63], b};
    if (wide[64] != wide[63]) return wide[64] ? 64'sh8000_0000_0000_0000
                                              : 64'sh7FFF_FFFF_FFFF_FFFF;
    return wide[63:0];
  endfunction

  // (x * rate) >> 16 with the magnitude truncated, saturated to the 48-bit gradient range
  function automatic longint rate_scale(input longint x, input logic [31:0] rate);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] lim;
    neg  = x < 0;
    mag  = neg ? -x : x;
    prod = (mag >> 16) * {32'd0, rate} + (((mag & 64'hFFFF) * {32'd0, rate}) >> 16);
    lim  = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic void model_beat(input op_t op, input logic signed [31:0] f,
                                     input logic signed [31:0] m, input logic [15:0] n,
                                     output bit got, output result_t r);
    int     d;
    int     k;
    bit     last;
    longint s;
    longint divisor;
    got = 0;
    r   = '0;
    d   = (dims_mirror == 0) ? 1 : ((dims_mirror > DIMS_CAP) ? DIMS_CAP : dims_mirror);
    if (op == OP_APPLY || op == OP_CLEAR) begin
      // both abandon any vector in progress
      elem_mirror = 0;
      acc_mirror  = 0;
      if (op == OP_CLEAR) begin
        foreach (grad_mirror[i]) grad_mirror[i] = 0;
      end else begin
        divisor = (n == 0) ? 1 : n;
        for (k = 0; k <= d; k++)
          weight_mirror[k] = int'(clamp32(longint'(weight_mirror[k]) - grad_mirror[k] / divisor));
        got = 1;
        r   = '{kind: KIND_UPDATE, score: '0};
      end
      return;
    end
    // score and accumulate share the element counter
    k    = (elem_mirror > d - 1) ? d - 1 : elem_mirror;
    last = (k == d - 1);
    if (op == OP_SCORE) begin
      acc_mirror = acc_add(acc_mirror, longint'(f) * longint'(weight_mirror[k]));
      if (last) begin
        s   = clamp32(clamp32(acc_mirror >>> 16) + longint'(weight_mirror[d]));
        got = 1;
        r   = '{kind: KIND_SCORE, score: s[31:0]};
      end
    end else begin
      grad_mirror[k] = clamp48(grad_mirror[k]
                               + rate_scale((longint'(f) * longint'(m)) >>> 16, rate_mirror));
      // end of a training vector also feeds the bias gradient
      if (last) grad_mirror[d] = clamp48(grad_mirror[d] + rate_scale(longint'(m), rate_mirror));
    end
    if (last) begin
      elem_mirror = 0;
      acc_mirror  = 0;
    end else begin
      elem_mirror = k + 1;
    end
  endfunction

  // ---------------------------------------------------------------- register port
  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);       // write lands here, pready is tied high
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_RATE) rate_mirror = val;
    else dims_mirror = val[6:0];
  endtask

  // ---------------------------------------------------------------- input beats
  // sender runs in bursts; a gap drops valid only between beats, never under a stall
  task automatic send_beat(input op_t op, input logic [31:0] f, input logic [31:0] m,
                           input logic [15:0] n, input bit typed = 0,
                           input result_t want = '0);
    int      gap;
    bit      got;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    operation  <= op;
    feature    <= f;
    mult       <= m;
    batch_size <= n;
    do @(posedge clk); while (in_stall);
    items_sent++;
    model_beat(op, f, m, n, got, r);
    if (got) pending_results.push_back(typed ? want : r);
  endtask

  // drain everything, then let an accumulate tail settle before touching registers
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mix of full-range, near-unity, extreme and small values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      2: case ($urandom_range(0, 2))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           default: return 32'h0;
         endcase
      default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_batch();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 2));
      1: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------- result side
  // stall pattern follows cyc[9:8]; a requested hold-off overrides it
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_req  <= 1'b0;
    end else begin
      case (cyc[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= 1'($urandom_range(0, 1));
        2'd2: out_stall <= (cyc % 5 == 0);
        default: out_stall <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat kind %0d score %h", result_kind, score_value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_kind !== exp_r.kind) begin
          $error("result_kind exp %0d got %0d", exp_r.kind, result_kind);
          errors++;
        end
        if (score_value !== exp_r.score) begin
          $error("score_value exp %h got %h", exp_r.score, score_value);
          errors++;
        end
        if (exp_r.kind == KIND_SCORE) scores_seen++;
        else updates_seen++;
      end
    end
  end

  // watchdog: no beat moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  row_t directed [] = '{
    // dims 1, rate 1.0: one feature plus bias, all weights 1.0
    '{OP_SCORE, 32'h0001_0000, 32'h0, 16'd0, 1, '{KIND_SCORE, 32'h0002_0000}},
    '{OP_SCORE, 32'h7FFF_FFFF, 32'h0, 16'd0, 1, '{KIND_SCORE, 32'h7FFF_FFFF}},
    '{OP_SCORE, 32'h8000_0000, 32'h0, 16'd0, 1, '{KIND_SCORE, 32'h8001_0000}},
    '{OP_SCORE, 32'h0,         32'h0, 16'd0, 1, '{KIND_SCORE, 32'h0001_0000}},
    '{OP_APPLY, 32'h0, 32'h0, 16'd1, 1, '{KIND_UPDATE, 32'h0}},
    '{OP_ACCUM, 32'h0001_0000, 32'h0001_0000, 16'd0, 0, '0},
    // zero batch size acts as one
    '{OP_APPLY, 32'h0, 32'h0, 16'd0, 1, '{KIND_UPDATE, 32'h0}},
    '{OP_SCORE, 32'h0001_0000, 32'h0, 16'd0, 0, '0},
    '{OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 0, '0},
    '{OP_ACCUM, 32'h8000_0000, 32'h8000_0000, 16'd0, 0, '0},
    '{OP_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 0, '0},
    '{OP_APPLY, 32'h0, 32'h0, 16'hFFFF, 1, '{KIND_UPDATE, 32'h0}},
    '{OP_SCORE, 32'h7FFF_FFFF, 32'h0, 16'd0, 0, '0},
    '{OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, '0},
    '{OP_SCORE, 32'h0001_0000, 32'h0, 16'd0, 0, '0},
    // tiny negative product floors away from zero
    '{OP_ACCUM, 32'hFFFF_FFFF, 32'h0000_0001, 16'd0, 0, '0},
    '{OP_APPLY, 32'h0, 32'h0, 16'd3, 1, '{KIND_UPDATE, 32'h0}},
    '{OP_SCORE, 32'h1234_5678, 32'h0, 16'd0, 0, '0}
  };

  // per-phase settings, extremes included; dims 0 and 127 exercise the clamping
  logic [31:0] phase_rate [PHASES] = '{32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_0000,
                                       32'h0002_0000, 32'h0000_0001, 32'h0001_0000,
                                       32'h0000_4000};
  logic [6:0]  phase_dims [PHASES] = '{7'd3, 7'd2, 7'd5, 7'd0, 7'd127, 7'd8, 7'd64, 7'd4};

  initial begin
    int   eff;
    int   start;
    int   pick;
    op_t  vec_op;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= OP_SCORE;
    feature    <= '0;
    mult       <= '0;
    batch_size <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    cyc       = 0;
    hold_req  = 1'b0;
    errors    = 0;
    items_sent = 0;
    scores_seen = 0;
    updates_seen = 0;
    burst_left = 0;
    foreach (weight_mirror[i]) weight_mirror[i] = int'(WEIGHT_ONE);
    foreach (grad_mirror[i]) grad_mirror[i] = 0;
    elem_mirror = 0;
    acc_mirror  = 0;
    rate_mirror = RATE_RESET;
    dims_mirror = 7'd64;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: single-element vectors so every beat is a complete vector
    reg_write(REG_RATE, RATE_RESET);
    reg_write(REG_DIMS, 32'd1);
    foreach (directed[i])
      send_beat(directed[i].op, directed[i].feat, directed[i].mul, directed[i].batch,
                directed[i].typed, directed[i].want);
    wait_drained();

    // random part: mostly whole vectors with random content, some broken ones and noise
    for (int p = 0; p < PHASES; p++) begin
      reg_write(REG_RATE, phase_rate[p]);
      reg_write(REG_DIMS, {25'd0, phase_dims[p]});
      eff   = (dims_mirror == 0) ? 1 : ((dims_mirror > DIMS_CAP) ? DIMS_CAP : dims_mirror);
      start = items_sent;
      // one long receiver hold-off during a phase with short score vectors
      if (p == 2) hold_req = 1'b1;
      while (items_sent - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          vec_op = (pick < 45) ? OP_SCORE : OP_ACCUM;
          // a vector cut short now and then, finished by whatever comes next
          for (int j = 0; j < (($urandom_range(0, 9) == 0) ? $urandom_range(1, eff) : eff); j++)
            send_beat(vec_op, pick_value(), pick_value(), pick_batch());
        end else if (pick < 88) begin
          send_beat(OP_APPLY, pick_value(), pick_value(), pick_batch());
        end else if (pick < 92) begin
          send_beat(OP_CLEAR, pick_value(), pick_value(), pick_batch());
        end else begin
          repeat ($urandom_range(1, 3))
            send_beat(op_t'($urandom_range(0, 3)), pick_value(), pick_value(), pick_batch());
        end
      end
      wait_drained();
    end

    $display("covered %0d input beats over %0d register settings, dims 0..127, rate 0..max",
             items_sent, PHASES + 1);
    $display("checked %0d scores and %0d weight updates, with a long receiver hold-off",
             scores_seen, updates_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
